### design/bcom_pkg.sv
// Package for the biped center-of-mass block: payload types, constants, sine polynomial.
package bcom_pkg;

  localparam int unsigned AngleSteps = 4096;
  localparam int unsigned FracBits   = 4;
  localparam int unsigned MotorW     = $clog2(AngleSteps);

  // Register levels from input item to result: 8 per leg lane, 4 in the merge.
  localparam int unsigned PipeLat = 12;

  localparam logic [14:0] SinC1 = 15'd25736;
  localparam logic [13:0] SinC3 = 14'd10544;
  localparam logic [10:0] SinC5 = 11'd1192;

  localparam logic signed [21:0] WKnee = 22'sd1149815;
  localparam logic signed [21:0] WFoot = 22'sd1235096;
  localparam logic signed [23:0] WBody = 24'sd7888823;
  localparam logic signed [20:0] WHip  = 21'sd525722;

  localparam logic [1:0] CfgShin  = 2'd0;
  localparam logic [1:0] CfgHipX  = 2'd1;
  localparam logic [1:0] CfgSpace = 2'd2;
  localparam logic [1:0] CfgBody  = 2'd3;

  typedef struct packed {
    logic signed [15:0] left_foot_x;
    logic signed [15:0] left_foot_y;
    logic signed [15:0] left_foot_z;
    logic [11:0] left_thigh_motor;
    logic [11:0] left_twist_motor;
    logic [11:0] left_roll_motor;
    logic signed [15:0] right_foot_x;
    logic signed [15:0] right_foot_y;
    logic signed [15:0] right_foot_z;
    logic [11:0] right_thigh_motor;
    logic [11:0] right_twist_motor;
    logic [11:0] right_roll_motor;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] com_x;
    logic signed [15:0] com_y;
    logic signed [15:0] com_z;
    logic saturated;
  } out_item_t;

  typedef struct packed {
    logic [12:0] shin_length;
    logic [11:0] hip_offset_x;
    logic [12:0] hip_spacing;
    logic signed [15:0] body_offset_x;
  } cfg_t;

  // Map a motor value onto a 16-bit turn.
  function automatic logic [15:0] motor_phase(input logic [11:0] m);
    logic [31:0] p;
    begin
      p = ({20'd0, m} * 32'd65536) / AngleSteps;
      return p[15:0];
    end
  endfunction

  // Quadrant fold of a phase: reduced argument (the sign is taken from phase bit 15 by the caller).
  function automatic logic [14:0] fold_x(input logic [15:0] ph);
    logic [14:0] r;
    begin
      r = {1'b0, ph[13:0]};
      return ph[14] ? (15'd16384 - r) : r;
    end
  endfunction

endpackage

### design/bcom_sine.sv
// Pipelined Q14 sine polynomial, four register stages.
module bcom_sine (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [15:0]        phase_i,
  output logic signed [15:0] sin_o
);

  logic [14:0] x1_q, x2_q, x3_q;
  logic        n1_q, n2_q, n3_q;
  logic [14:0] sq_q, sq2_q;
  logic [14:0] inner_q;
  logic [15:0] poly_q;
  logic [29:0] sq_full, t5, t3;
  logic [29:0] xp;

  assign sq_full = {15'd0, bcom_pkg::fold_x(phase_i)} * {15'd0, bcom_pkg::fold_x(phase_i)};

  // Square, inner term, polynomial, final product.
  always_comb begin
    t5 = {15'd0, sq_q} * {19'd0, bcom_pkg::SinC5};
    t3 = {15'd0, sq2_q} * {15'd0, inner_q};
    xp = {15'd0, x3_q} * {14'd0, poly_q};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x1_q    <= bcom_pkg::fold_x(phase_i);
      n1_q    <= phase_i[15];
      sq_q    <= sq_full[28:14];
      x2_q    <= x1_q;
      n2_q    <= n1_q;
      sq2_q   <= sq_q;
      inner_q <= {1'b0, bcom_pkg::SinC3} - t5[28:14];
      x3_q    <= x2_q;
      n3_q    <= n2_q;
      poly_q  <= {1'b0, bcom_pkg::SinC1} - {1'b0, t3[28:14]};
      sin_o   <= n3_q ? -$signed({1'b0, xp[28:14]}) : $signed({1'b0, xp[28:14]});
    end
  end

endmodule

### design/bcom_leg.sv
// One leg lane: sines, rotation and knee position, Q14-scaled output.
module bcom_leg (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [11:0]        ma_i,
  input  logic [11:0]        mb_i,
  input  logic [11:0]        mc_i,
  input  logic [12:0]        len_i,
  input  logic [11:0]        hipx_i,
  output logic signed [43:0] kx_o,
  output logic signed [43:0] ky_o,
  output logic signed [43:0] kz_o
);

  logic signed [15:0] sa, ca, sb, cb, sc, cc;
  logic [15:0] pa, pb, pc;
  logic signed [31:0] u_full;
  logic signed [17:0] u_q;
  logic signed [15:0] sa1_q, cc1_q, ca1_q, sb1_q, cb1_q;
  logic signed [31:0] gx_q, cacb_q, casb_q;
  logic signed [33:0] usb_q, ucb_q;
  logic signed [34:0] gx2_q, gy_q, gz_q;
  logic signed [48:0] lx, ly, lz;

  assign pa = bcom_pkg::motor_phase(ma_i);
  assign pb = bcom_pkg::motor_phase(mb_i);
  assign pc = bcom_pkg::motor_phase(mc_i);

  bcom_sine u_sa (.clk_i, .en_i, .phase_i(pa), .sin_o(sa));
  bcom_sine u_ca (.clk_i, .en_i, .phase_i(pa + 16'd16384), .sin_o(ca));
  bcom_sine u_sb (.clk_i, .en_i, .phase_i(pb), .sin_o(sb));
  bcom_sine u_cb (.clk_i, .en_i, .phase_i(pb + 16'd16384), .sin_o(cb));
  bcom_sine u_sc (.clk_i, .en_i, .phase_i(pc), .sin_o(sc));
  bcom_sine u_cc (.clk_i, .en_i, .phase_i(pc + 16'd16384), .sin_o(cc));

  assign u_full = sa * sc;
  assign lx = $signed({1'b0, len_i}) * gx2_q;
  assign ly = $signed({1'b0, len_i}) * gy_q;
  assign lz = $signed({1'b0, len_i}) * gz_q;

  // Stage products of the rotation, then the shin scaling.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      u_q    <= u_full[31:14];
      sa1_q  <= sa;
      cc1_q  <= cc;
      ca1_q  <= ca;
      sb1_q  <= sb;
      cb1_q  <= cb;
      gx_q   <= sa1_q * cc1_q;
      cacb_q <= ca1_q * cb1_q;
      casb_q <= ca1_q * sb1_q;
      usb_q  <= u_q * sb1_q;
      ucb_q  <= u_q * cb1_q;
      gx2_q  <= 35'(gx_q);
      gy_q   <= 35'(cacb_q) - 35'(usb_q);
      gz_q   <= 35'(casb_q) + 35'(ucb_q);
      kx_o   <= 44'(lx >>> 14) + $signed({18'd0, hipx_i, 14'd0});
      ky_o   <= 44'(ly >>> 14);
      kz_o   <= 44'(lz >>> 14);
    end
  end

endmodule

### design/bcom_merge.sv
// Merge stage: weighted sums of both legs and body, rounding and clipping.
module bcom_merge (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic signed [43:0]  klx_i, kly_i, klz_i,
  input  logic signed [43:0]  krx_i, kry_i, krz_i,
  input  logic signed [16:0]  fx_i, fy_i, fz_i,
  input  bcom_pkg::cfg_t      cfg_i,
  output bcom_pkg::out_item_t res_o
);

  logic signed [44:0] sx_q, sy_q, sz_q;
  logic signed [16:0] fx_q, fy_q, fz_q;
  logic signed [66:0] px_q, py_q, pz_q, qx_q, qy_q, qz_q;
  logic signed [66:0] ax_q, ay_q, az_q;
  logic signed [66:0] bx, by, bz;
  logic signed [28:0] vx, vy, vz;
  logic ox, oy, oz;

  // Weights are constants.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sx_q <= 45'(klx_i) + 45'(krx_i);
      sy_q <= 45'(kly_i) + 45'(kry_i);
      sz_q <= 45'(krz_i) - 45'(klz_i);
      fx_q <= fx_i;
      fy_q <= fy_i;
      fz_q <= fz_i;
      px_q <= 67'(sx_q) * 67'(bcom_pkg::WKnee);
      py_q <= 67'(sy_q) * 67'(bcom_pkg::WKnee);
      pz_q <= 67'(sz_q) * 67'(bcom_pkg::WKnee);
      qx_q <= (67'(fx_q) * 67'(bcom_pkg::WFoot)
              + 67'(cfg_i.body_offset_x) * 67'(bcom_pkg::WBody)) <<< 14;
      qy_q <= (67'(fy_q) * 67'(bcom_pkg::WFoot)) <<< 14;
      qz_q <= (67'(fz_q) * 67'(bcom_pkg::WFoot)
              - 67'($signed({1'b0, cfg_i.hip_spacing})) * 67'(bcom_pkg::WHip)) <<< 14;
      ax_q <= px_q + qx_q;
      ay_q <= py_q + qy_q;
      az_q <= pz_q + qz_q;
    end
  end

  assign bx = (ax_q + (67'sd1 <<< 37)) >>> 38;
  assign by = (ay_q + (67'sd1 <<< 37)) >>> 38;
  assign bz = (az_q + (67'sd1 <<< 37)) >>> 38;
  assign vx = bx[28:0];
  assign vy = by[28:0];
  assign vz = bz[28:0];
  assign ox = (vx > 29'sd32767) || (vx < -29'sd32768);
  assign oy = (vy > 29'sd32767) || (vy < -29'sd32768);
  assign oz = (vz > 29'sd32767) || (vz < -29'sd32768);

  // Clip each axis and flag.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_o.com_x <= ox ? (vx[28] ? 16'sh8000 : 16'sh7fff) : vx[15:0];
      res_o.com_y <= oy ? (vy[28] ? 16'sh8000 : 16'sh7fff) : vy[15:0];
      res_o.com_z <= oz ? (vz[28] ? 16'sh8000 : 16'sh7fff) : vz[15:0];
      res_o.saturated <= ox | oy | oz;
    end
  end

endmodule

### design/biped_center_of_mass.sv
// Top level of the biped center-of-mass pipeline.
//   channel | direction | handshake
//   in      | input     | in_valid_i / in_stall_o, payload in_data_i
//   out     | output    | out_valid_o / out_stall_i, payload out_data_o
//   cfg     | input     | cfg_we_i, cfg_idx_i, cfg_data_i
// One item enters every cycle while the output is not stalled; 12 register stages: 8 in each
// leg lane (4 sine pipeline, then rotation products and shin scaling) and 4 in the merge stage.
// The whole pipeline advances when the output is not stalled or empty.
// Reset clears valid flags and loads register defaults.
module biped_center_of_mass (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bcom_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bcom_pkg::out_item_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [15:0]         cfg_data_i
);

  bcom_pkg::cfg_t cfg_q;
  logic [bcom_pkg::PipeLat-1:0] vld_q;
  logic en;
  logic signed [43:0] klx, kly, klz, krx, kry, krz;
  logic signed [16:0] fx_q [8], fy_q [8], fz_q [8];

  assign en = !(vld_q[bcom_pkg::PipeLat-1] && out_stall_i);
  assign in_stall_o = !en;
  assign out_valid_o = vld_q[bcom_pkg::PipeLat-1];

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.shin_length   <= 13'd2720;
      cfg_q.hip_offset_x  <= 12'd556;
      cfg_q.hip_spacing   <= 13'd1920;
      cfg_q.body_offset_x <= -16'sd3260;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bcom_pkg::CfgShin:  cfg_q.shin_length   <= cfg_data_i[12:0];
        bcom_pkg::CfgHipX:  cfg_q.hip_offset_x  <= cfg_data_i[11:0];
        bcom_pkg::CfgSpace: cfg_q.hip_spacing   <= cfg_data_i[12:0];
        bcom_pkg::CfgBody:  cfg_q.body_offset_x <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Advance valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (en) vld_q <= {vld_q[bcom_pkg::PipeLat-2:0], in_valid_i};
  end

  // Delay foot sums to meet the knee results.
  always_ff @(posedge clk_i) begin
    if (en) begin
      fx_q[0] <= 17'(in_data_i.left_foot_x) + 17'(in_data_i.right_foot_x);
      fy_q[0] <= 17'(in_data_i.left_foot_y) + 17'(in_data_i.right_foot_y);
      fz_q[0] <= 17'(in_data_i.right_foot_z) - 17'(in_data_i.left_foot_z);
      for (int i = 1; i < 8; i++) begin
        fx_q[i] <= fx_q[i-1];
        fy_q[i] <= fy_q[i-1];
        fz_q[i] <= fz_q[i-1];
      end
    end
  end

  bcom_leg u_left (
    .clk_i, .en_i(en),
    .ma_i(in_data_i.left_thigh_motor), .mb_i(in_data_i.left_twist_motor),
    .mc_i(in_data_i.left_roll_motor), .len_i(cfg_q.shin_length),
    .hipx_i(cfg_q.hip_offset_x), .kx_o(klx), .ky_o(kly), .kz_o(klz)
  );

  bcom_leg u_right (
    .clk_i, .en_i(en),
    .ma_i(in_data_i.right_thigh_motor), .mb_i(in_data_i.right_twist_motor),
    .mc_i(in_data_i.right_roll_motor), .len_i(cfg_q.shin_length),
    .hipx_i(cfg_q.hip_offset_x), .kx_o(krx), .ky_o(kry), .kz_o(krz)
  );

  bcom_merge u_merge (
    .clk_i, .en_i(en),
    .klx_i(klx), .kly_i(kly), .klz_i(klz),
    .krx_i(krx), .kry_i(kry), .krz_i(krz),
    .fx_i(fx_q[7]), .fy_i(fy_q[7]), .fz_i(fz_q[7]),
    .cfg_i(cfg_q), .res_o(out_data_o)
  );

endmodule
